// ----- src/ursq_pkg.sv -----
// ----------------------------------------------------------------------------
// ursq_pkg
// Shared types and constants for the ultrasonic ranging sequencer.
// ----------------------------------------------------------------------------
package ursq_pkg;

  localparam int MAX_SENSORS  = 4;
  localparam int ECHO_W       = 4;
  localparam int IDX_W        = $clog2(MAX_SENSORS + 1);
  localparam int NUM_W        = 3;
  localparam int TIMEOUT_W    = 16;
  localparam int TRIG_W       = 8;
  localparam int PAUSE_W      = 20;
  localparam int SENSORS_W    = 3;
  localparam int ELAPSED_W    = 20;
  localparam int WIDTH_W      = 17;
  localparam int DIST_W       = 17;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 20;
  localparam int IN_DATA_W    = 8;
  localparam int OUT_DATA_W   = 24;
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

  // distance = floor(width * 343 / 200) = (width * RECIP) >> RECIP_SHIFT
  localparam int RECIP_W      = 25;
  localparam int RECIP_SHIFT  = 24;
  localparam logic [RECIP_W-1:0] RECIP = 25'd28772926;
  localparam int PROD_W       = WIDTH_W + RECIP_W;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
  localparam logic [WIDTH_W-1:0]   WIDTH_MAX   = '1;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd50000;
  localparam logic [TRIG_W-1:0]    TRIG_RST    = 8'd10;
  localparam logic [PAUSE_W-1:0]   PAUSE_RST   = 20'd50000;
  localparam logic [SENSORS_W-1:0] SENSORS_RST = 3'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIMEOUT = 2'd0,
    REG_TRIGGER = 2'd1,
    REG_PAUSE   = 2'd2,
    REG_SENSORS = 2'd3
  } cfg_reg_t;

  typedef enum logic [4:0] {
    PH_WAIT_LOW  = 5'b00001,
    PH_TRIGGER   = 5'b00010,
    PH_WAIT_RISE = 5'b00100,
    PH_MEASURE   = 5'b01000,
    PH_PAUSE     = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [ECHO_W-1:0]  trig;
    logic               valid;
    logic [NUM_W-1:0]   number;
    logic [WIDTH_W-1:0] width;
  } raw_t;

endpackage

// ----- src/ursq_front.sv -----
// ----------------------------------------------------------------------------
// ursq_front
// Tick sequencer: holds configuration, steps the ranging state once per
// accepted tick and emits a raw record (trigger, reading flag, echo width).
// ----------------------------------------------------------------------------
module ursq_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic [ursq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ursq_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           tick,
  input  logic [ursq_pkg::ECHO_W-1:0]    echoes,
  output ursq_pkg::raw_t                 raw
);
  import ursq_pkg::*;

  logic [TIMEOUT_W-1:0] timeout_ticks;
  logic [TRIG_W-1:0]    trigger_ticks;
  logic [PAUSE_W-1:0]   pause_ticks;
  logic [SENSORS_W-1:0] sensors_in_use;

  phase_t               phase, phase_next;
  logic [IDX_W-1:0]     sensor_index, sensor_index_next;
  logic [ELAPSED_W-1:0] elapsed, elapsed_next;
  logic [WIDTH_W-1:0]   width, width_next;

  logic [IDX_W-1:0]     act;
  phase_t               ph_cur;
  logic [ELAPSED_W-1:0] el_cur;
  logic [ELAPSED_W-1:0] el_bump;
  logic [WIDTH_W-1:0]   w_inc;
  logic [IDX_W-1:0]     idx_inc;
  phase_t               ph_after;
  logic                 echo;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks  <= TIMEOUT_RST;
      trigger_ticks  <= TRIG_RST;
      pause_ticks    <= PAUSE_RST;
      sensors_in_use <= SENSORS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TIMEOUT: timeout_ticks  <= cfg_data[TIMEOUT_W-1:0];
        REG_TRIGGER: trigger_ticks  <= cfg_data[TRIG_W-1:0];
        REG_PAUSE:   pause_ticks    <= cfg_data[PAUSE_W-1:0];
        REG_SENSORS: sensors_in_use <= cfg_data[SENSORS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (sensors_in_use == '0) begin
      act = IDX_W'(1);
    end else if (32'(sensors_in_use) > MAX_SENSORS) begin
      act = IDX_W'(MAX_SENSORS);
    end else begin
      act = IDX_W'(sensors_in_use);
    end
  end

  always_comb begin
    ph_cur = phase;
    el_cur = elapsed;
    if (phase != PH_PAUSE && sensor_index >= act) begin
      ph_cur = PH_PAUSE;
      el_cur = '0;
    end
    echo     = (32'(sensor_index) < ECHO_W) ? echoes[sensor_index[1:0]] : 1'b0;
    el_bump  = (el_cur == ELAPSED_MAX) ? el_cur : el_cur + 1'b1;
    w_inc    = (width == WIDTH_MAX) ? width : width + 1'b1;
    idx_inc  = sensor_index + 1'b1;
    ph_after = (idx_inc >= act) ? PH_PAUSE : PH_WAIT_LOW;

    phase_next        = ph_cur;
    sensor_index_next = sensor_index;
    elapsed_next      = el_cur;
    width_next        = width;
    raw               = '0;

    unique case (ph_cur)
      PH_WAIT_LOW: begin
        elapsed_next = el_bump;
        if (!echo) begin
          phase_next = PH_TRIGGER;
          width_next = '0;
        end
      end
      PH_TRIGGER: begin
        if (32'(sensor_index) < ECHO_W) begin
          raw.trig = ECHO_W'(1) << sensor_index[1:0];
        end
        elapsed_next = el_bump;
        width_next   = w_inc;
        if (w_inc >= WIDTH_W'(trigger_ticks)) begin
          phase_next = PH_WAIT_RISE;
          width_next = '0;
        end
      end
      PH_WAIT_RISE: begin
        if (echo) begin
          phase_next   = PH_MEASURE;
          width_next   = WIDTH_W'(1);
          elapsed_next = el_bump;
        end else if (el_cur > ELAPSED_W'(timeout_ticks)) begin
          sensor_index_next = idx_inc;
          elapsed_next      = '0;
          width_next        = '0;
          phase_next        = ph_after;
        end else begin
          elapsed_next = el_bump;
        end
      end
      PH_MEASURE: begin
        if (echo) begin
          if (width > WIDTH_W'(timeout_ticks)) begin
            sensor_index_next = idx_inc;
            elapsed_next      = '0;
            width_next        = '0;
            phase_next        = ph_after;
          end else begin
            width_next   = w_inc;
            elapsed_next = el_bump;
          end
        end else begin
          raw.valid         = 1'b1;
          raw.number        = NUM_W'(idx_inc);
          raw.width         = width;
          sensor_index_next = idx_inc;
          elapsed_next      = '0;
          width_next        = '0;
          phase_next        = ph_after;
        end
      end
      PH_PAUSE: begin
        elapsed_next = el_bump;
        if (el_bump >= pause_ticks) begin
          phase_next        = PH_WAIT_LOW;
          sensor_index_next = '0;
          elapsed_next      = '0;
          width_next        = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_WAIT_LOW;
      sensor_index <= '0;
      elapsed      <= '0;
      width        <= '0;
    end else if (tick) begin
      phase        <= phase_next;
      sensor_index <= sensor_index_next;
      elapsed      <= elapsed_next;
      width        <= width_next;
    end
  end

  a_trig_onehot0: assert property (@(posedge clk) disable iff (rst)
    tick |-> $onehot0(raw.trig))
    else $error("more than one trigger driven");

  a_measure_width: assert property (@(posedge clk) disable iff (rst)
    phase == PH_MEASURE |-> width != '0)
    else $error("measuring with zero echo width");

  a_reading_in_range: assert property (@(posedge clk) disable iff (rst)
    tick && raw.valid |-> raw.number != '0 && 32'(raw.number) <= MAX_SENSORS
                          && raw.width != '0)
    else $error("reading outside sensor range or with zero width");

endmodule

// ----- src/ursq_fifo.sv -----
// ----------------------------------------------------------------------------
// ursq_fifo
// Short queue of raw records between the sequencer and the distance unit.
// ----------------------------------------------------------------------------
module ursq_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ursq_pkg::raw_t wdata,
  output logic           full,
  input  logic           pop,
  output ursq_pkg::raw_t rdata,
  output logic           empty
);
  import ursq_pkg::*;

  raw_t                  mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] count;

  assign full  = (count == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- src/ursq_back.sv -----
// ----------------------------------------------------------------------------
// ursq_back
// Distance unit: scales the echo width by a fixed reciprocal and holds the
// result in the output register until the transfer completes.
// ----------------------------------------------------------------------------
module ursq_back (
  input  logic                            clk,
  input  logic                            rst,
  input  ursq_pkg::raw_t                  rdata,
  input  logic                            empty,
  output logic                            pop,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [ursq_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                            m_tuser
);
  import ursq_pkg::*;

  logic               s1_valid;
  logic [ECHO_W-1:0]  s1_trig;
  logic               s1_flag;
  logic [NUM_W-1:0]   s1_number;
  logic [PROD_W-1:0]  s1_prod;
  logic               out_take;
  logic               s1_ready;
  logic [DIST_W-1:0]  distance;

  assign out_take = !m_tvalid || m_tready;
  assign s1_ready = !s1_valid || out_take;
  assign pop      = !empty && s1_ready;
  assign distance = s1_prod[RECIP_SHIFT +: DIST_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= !empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_trig   <= rdata.trig;
      s1_flag   <= rdata.valid;
      s1_number <= rdata.number;
      s1_prod   <= PROD_W'(rdata.width) * PROD_W'(RECIP);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_take) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take && s1_valid) begin
      m_tdata <= {distance, s1_number, s1_trig};
      m_tuser <= s1_flag;
    end
  end

  a_no_reading_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[OUT_DATA_W-1:ECHO_W] == '0)
    else $error("number or distance set without a reading");

  a_reading_number: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[ECHO_W +: NUM_W] != '0)
    else $error("reading without a sensor number");

  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_take |=> m_tvalid)
    else $error("stage result lost on the way out");

endmodule

// ----- src/ultrasonic_ranging_sequencer.sv -----
// ----------------------------------------------------------------------------
// ultrasonic_ranging_sequencer
// Round-robin echo ranging for up to four trigger/echo sensors.
// ----------------------------------------------------------------------------
// Each transfer on the s_ side is one microsecond tick with the echo pin
// levels; each tick gives exactly one transfer on the m_ side, in order,
// with the trigger levels to drive and, when m_tuser is high, a finished
// reading (sensor number and distance in hundredths of a cm). One tick is
// taken every clock cycle while the queue is not full: the sequencer steps
// its state once per tick. A reading passes through the queue, the
// reciprocal multiply and the output register on its way to m_; a
// four-entry queue lets ticks keep arriving while the output side stalls
// briefly. The configuration channel is always ready and should be written
// only while no ticks are in flight.
module ultrasonic_ranging_sequencer (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ursq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ursq_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [ursq_pkg::IN_DATA_W-1:0]   s_tdata,  // [3:0] echo_levels
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [ursq_pkg::OUT_DATA_W-1:0]  m_tdata,  // [3:0] trigger_levels,
                                                     // [6:4] sensor_number,
                                                     // [23:7] distance_centi_cm
  output logic                             m_tuser   // [0] reading_valid
);
  import ursq_pkg::*;

  raw_t raw;
  raw_t rdata;
  logic full;
  logic empty;
  logic pop;
  logic tick;

  assign cfg_ready = 1'b1;
  assign s_tready  = !full;
  assign tick      = s_tvalid && s_tready;

  ursq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tick      (tick),
    .echoes    (s_tdata[ECHO_W-1:0]),
    .raw       (raw)
  );

  ursq_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (tick),
    .wdata (raw),
    .full  (full),
    .pop   (pop),
    .rdata (rdata),
    .empty (empty)
  );

  ursq_back u_back (
    .clk      (clk),
    .rst      (rst),
    .rdata    (rdata),
    .empty    (empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
